@@ hdl/pca_projection_chi_square_defines.svh @@
// Assertion macros used by the checker file pcaps_chk.
`ifndef PCA_PROJECTION_CHI_SQUARE_DEFINES_SVH
`define PCA_PROJECTION_CHI_SQUARE_DEFINES_SVH

// Checked at every edge outside reset.
`define PCAPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCAPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pcaps_pkg.sv @@
// ----------------------------------------------------------------------------
// pcaps_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pcaps_pkg;

  localparam int DATA_W     = 24;
  localparam int VAL_W      = 48;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int LAYERS_DEF = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_COORD = 1'b1;

  localparam logic [1:0] SEL_MATRIX = 2'd0;
  localparam logic [1:0] SEL_MEAN   = 2'd1;
  localparam logic [1:0] SEL_INVSIG = 2'd2;
  localparam logic [1:0] SEL_INVEIG = 2'd3;

  typedef struct packed {
    logic             accept;
    logic             rd;
    logic             mul1;
    logic             mul2;
    logic             acc;
    logic             acc_clr;
    logic             sq;
    logic             chi_lo;
    logic             chi_hi;
    logic             chi_add;
    logic             chi_clr;
    logic             emit;
    logic             last;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] i;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ hdl/pcaps_dp.sv @@
// ----------------------------------------------------------------------------
// pcaps_dp
// Table stores, coordinate buffer, projection MAC and chi-square datapath,
// with the result output register.
// ----------------------------------------------------------------------------
module pcaps_dp
  import pcaps_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic                     cfg_valid,
  input  logic [3:0]               cfg_data,
  input  logic                     req_type,
  input  logic [1:0]               table_select,
  input  logic [3:0]               entry_row,
  input  logic [3:0]               entry_col,
  input  logic signed [DATA_W-1:0] word_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         component_index,
  output logic signed [VAL_W-1:0]  component_value,
  output logic [VAL_W-1:0]         chi_square,
  output logic                     tail_error,
  output logic                     last_result
);

  localparam int DIM = 3 * LAYERS;
  localparam int MD  = DIM * DIM;
  localparam int IW  = $clog2(DIM);
  localparam int MW  = $clog2(MD);

  logic signed [DATA_W-1:0] mat  [MD];
  logic signed [DATA_W-1:0] mean [DIM];
  logic signed [DATA_W-1:0] isig [DIM];
  logic signed [DATA_W-1:0] ieig [DIM];
  logic signed [DATA_W-1:0] xbuf [DIM];

  logic [3:0] tail_layers;

  logic            row_ok, col_ok;
  logic [IW-1:0]   wr_row;
  logic [MW-1:0]   wr_maddr, rd_maddr;
  logic [2*CNT_W-1:0] wr_mlin, rd_mlin;

  assign row_ok   = CNT_W'(entry_row) < CNT_W'(DIM);
  assign col_ok   = CNT_W'(entry_col) < CNT_W'(DIM);
  assign wr_row   = IW'(entry_row);
  assign wr_mlin  = (2*CNT_W)'(entry_row) * (2*CNT_W)'(DIM) + (2*CNT_W)'(entry_col);
  assign wr_maddr = wr_mlin[MW-1:0];
  assign rd_mlin  = (2*CNT_W)'(cmd.j) * (2*CNT_W)'(DIM) + (2*CNT_W)'(cmd.i);
  assign rd_maddr = rd_mlin[MW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_layers <= '0;
    end else if (cfg_valid) begin
      tail_layers <= cfg_data;
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (cmd.accept && row_ok) begin
      if (req_type == REQ_COORD) begin
        xbuf[wr_row] <= word_value;
      end else begin
        unique case (table_select)
          SEL_MATRIX: if (col_ok) mat[wr_maddr] <= word_value;
          SEL_MEAN:   mean[wr_row] <= word_value;
          SEL_INVSIG: isig[wr_row] <= word_value;
          SEL_INVEIG: ieig[wr_row] <= word_value;
          default: ;
        endcase
      end
    end
  end

  // registered reads
  logic signed [DATA_W-1:0] x_q, mean_q, isig_q, ieig_q, mat_q;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      x_q    <= xbuf[cmd.j[IW-1:0]];
      mean_q <= mean[cmd.j[IW-1:0]];
      isig_q <= isig[cmd.j[IW-1:0]];
      ieig_q <= ieig[cmd.i[IW-1:0]];
      mat_q  <= mat[rd_maddr];
    end
  end

  // projection term
  logic signed [DATA_W:0]   d;
  logic signed [48:0]       prod1;
  logic signed [36:0]       s;
  logic signed [60:0]       prod2;
  logic signed [48:0]       t;
  logic signed [49:0]       acc_sum;
  logic signed [VAL_W-1:0]  acc;
  logic signed [48:0]       prod1_r;
  logic signed [60:0]       prod2_r;

  assign d     = (DATA_W+1)'(x_q) - (DATA_W+1)'(mean_q);
  assign prod1 = 49'(d) * 49'(isig_q);
  assign s     = 37'((prod1_r + 49'sd2048) >>> 12);
  assign prod2 = 61'(s) * 61'(mat_q);
  assign t     = 49'((prod2_r + 61'sd2048) >>> 12);
  assign acc_sum = 50'(acc) + 50'(t);

  always_ff @(posedge clk) begin
    if (cmd.mul1) prod1_r <= prod1;
    if (cmd.mul2) prod2_r <= prod2;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc) begin
      if (acc_sum > 50'sh7FFF_FFFF_FFFF)        acc <= {1'b0, {(VAL_W-1){1'b1}}};
      else if (acc_sum < -50'sh8000_0000_0000) acc <= {1'b1, {(VAL_W-1){1'b0}}};
      else                                       acc <= acc_sum[VAL_W-1:0];
    end
  end

  // chi-square term: round12(sq * ieig) split into high and low halves of sq
  logic [VAL_W-1:0]   absp;
  logic               big_r;
  logic [59:0]        sqm_r;
  logic [48:0]        sq_raw;
  logic [VAL_W-1:0]   sq;
  logic signed [48:0] lo_ie_r, hi_ie_r;
  logic signed [63:0] term, chi;
  logic [6:0]         tail3;
  logic               err, in_tail;

  assign absp   = acc[VAL_W-1] ? VAL_W'(-acc) : VAL_W'(acc);
  assign sq_raw = 49'((61'(sqm_r) + 61'd2048) >> 12);
  assign sq     = big_r ? {VAL_W{1'b1}} : sq_raw[VAL_W-1:0];
  assign term   = (64'(hi_ie_r) <<< 12) + 64'((lo_ie_r + 49'sd2048) >>> 12);
  assign tail3  = 7'(tail_layers) * 7'd3;
  assign err    = tail3 > 7'(DIM);
  assign in_tail = (7'(cmd.i) + tail3) >= 7'(DIM);

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      big_r <= absp >= VAL_W'(64'h4000_0000);
      sqm_r <= 60'(absp[29:0]) * 60'(absp[29:0]);
    end
    if (cmd.chi_lo) lo_ie_r <= 49'($signed({1'b0, sq[23:0]})) * 49'(ieig_q);
    if (cmd.chi_hi) hi_ie_r <= 49'($signed({1'b0, sq[47:24]})) * 49'(ieig_q);
    if (cmd.chi_clr) begin
      chi <= '0;
    end else if (cmd.chi_add && in_tail && !err) begin
      chi <= chi + term;
    end
  end

  logic [VAL_W-1:0] chi_clamped;
  assign chi_clamped = chi[63] ? '0 :
                       (chi > 64'sh0000_FFFF_FFFF_FFFF) ? {VAL_W{1'b1}} : chi[VAL_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      component_index <= IDX_W'(cmd.i);
      component_value <= acc;
      last_result     <= cmd.last;
      tail_error      <= cmd.last && err;
      chi_square      <= (cmd.last && !err) ? chi_clamped : '0;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

@@ hdl/pcaps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcaps_ctrl
// Sequencer: walks components i and coordinates j, issuing datapath steps.
// ----------------------------------------------------------------------------
module pcaps_ctrl
  import pcaps_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    req_type,
  input  logic    last_coord,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int DIM = 3 * LAYERS;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(DIM - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_CL   = 4'd6;
  localparam logic [3:0] S_CH   = 4'd7;
  localparam logic [3:0] S_CA   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] i, i_next, j, j_next;
  logic             start, emit_ok;

  assign in_ready = state == S_IDLE;
  assign start    = in_valid && in_ready && req_type == REQ_COORD && last_coord;
  assign emit_ok  = state == S_EMIT && !status.out_busy;

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    unique case (state)
      S_IDLE: if (start) begin
        state_next = S_RD;
        i_next     = '0;
        j_next     = '0;
      end
      S_RD:  state_next = S_M1;
      S_M1:  state_next = S_M2;
      S_M2:  state_next = S_ACC;
      S_ACC: begin
        if (j == LAST_IDX) begin
          state_next = S_SQ;
        end else begin
          j_next     = j + 1'b1;
          state_next = S_RD;
        end
      end
      S_SQ:  state_next = S_CL;
      S_CL:  state_next = S_CH;
      S_CH:  state_next = S_CA;
      S_CA:  state_next = S_EMIT;
      S_EMIT: if (emit_ok) begin
        if (i == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          i_next     = i + 1'b1;
          j_next     = '0;
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.accept  = in_valid && in_ready;
    cmd.rd      = state == S_RD;
    cmd.mul1    = state == S_M1;
    cmd.mul2    = state == S_M2;
    cmd.acc     = state == S_ACC;
    cmd.acc_clr = start || emit_ok;
    cmd.sq      = state == S_SQ;
    cmd.chi_lo  = state == S_CL;
    cmd.chi_hi  = state == S_CH;
    cmd.chi_add = state == S_CA;
    cmd.chi_clr = start;
    cmd.emit    = emit_ok;
    cmd.last    = i == LAST_IDX;
    cmd.i       = i;
    cmd.j       = j;
  end

endmodule

@@ hdl/pca_projection_chi_square.sv @@
// Sequence: a last coordinate starts a projection of DIM components; each
// component takes four steps per coordinate (read, multiply, multiply, accumulate)
// through the shared MAC, then the chi-square term. Loads and coordinates
// are accepted only while the sequencer is idle.
// Reset (synchronous, active high) clears the sequencer, output valid and
// tail_layers; the table stores are undefined until loaded.
// ----------------------------------------------------------------------------
// pca_projection_chi_square
// Principal component projection of one track with tail chi-square.
// ----------------------------------------------------------------------------
module pca_projection_chi_square
  import pcaps_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [3:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     req_type,
  input  logic [1:0]               table_select,
  input  logic [3:0]               entry_row,
  input  logic [3:0]               entry_col,
  input  logic signed [DATA_W-1:0] word_value,
  input  logic                     last_coord,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         component_index,
  output logic signed [VAL_W-1:0]  component_value,
  output logic [VAL_W-1:0]         chi_square,
  output logic                     tail_error,
  output logic                     last_result
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pcaps_ctrl #(.LAYERS(LAYERS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .last_coord (last_coord),
    .status     (status),
    .cmd        (cmd)
  );

  pcaps_dp #(.LAYERS(LAYERS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .table_select    (table_select),
    .entry_row       (entry_row),
    .entry_col       (entry_col),
    .word_value      (word_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .component_index (component_index),
    .component_value (component_value),
    .chi_square      (chi_square),
    .tail_error      (tail_error),
    .last_result     (last_result)
  );

endmodule

@@ hdl/pcaps_chk.sv @@
// ----------------------------------------------------------------------------
// pcaps_chk
// Port-level checks on the result channel and on reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "pca_projection_chi_square_defines.svh"

module pcaps_chk
  import pcaps_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] component_value,
  input logic [VAL_W-1:0]        chi_square,
  input logic                    tail_error,
  input logic                    last_result
);

  `PCAPS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(component_value), "result beat dropped or changed while stalled")
  `PCAPS_ASSERT(a_err_last, out_valid && tail_error |-> last_result && chi_square == '0, "tail error off the final beat or with a chi-square")
  `PCAPS_ASSERT(a_chi_last, out_valid && !last_result |-> chi_square == '0, "chi-square on a non-final beat")
  `PCAPS_ASSERT_ALWAYS(a_rst, rst |=> !out_valid && in_ready, "reset left a result pending or input blocked")

endmodule

bind pca_projection_chi_square pcaps_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .component_value (component_value),
  .chi_square      (chi_square),
  .tail_error      (tail_error),
  .last_result     (last_result)
);

@@ dv/pca_projection_chi_square_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_projection_chi_square_tb
// Loads the projection tables, sends tracks and table reloads through the
// valid/ready input, and checks every component beat, with its chi-square
// and tail error flag, against a predictor of the projection.
// ----------------------------------------------------------------------------
module pca_projection_chi_square_tb;
  import pcaps_pkg::*;

  localparam int DIM = 3 * LAYERS_DEF;
  localparam longint SMAX = 64'sd140737488355327;
  localparam longint SMIN = -64'sd140737488355328;
  localparam longint UMAX = 64'sd281474976710655;

  typedef struct {
    logic             req;
    logic [1:0]       sel;
    logic [3:0]       row;
    logic [3:0]       col;
    logic [DATA_W-1:0] val;
    logic             last;
  } hit_item_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] comp;
    logic [VAL_W-1:0] chi;
    logic             err;
    logic             last;
  } component_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [1:0] table_select = '0;
  logic [3:0] entry_row = '0;
  logic [3:0] entry_col = '0;
  logic signed [DATA_W-1:0] word_value = '0;
  logic last_coord = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] component_index;
  logic signed [VAL_W-1:0] component_value;
  logic [VAL_W-1:0] chi_square;
  logic tail_error;
  logic last_result;

  pca_projection_chi_square dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .table_select(table_select), .entry_row(entry_row),
    .entry_col(entry_col), .word_value(word_value), .last_coord(last_coord),
    .out_valid(out_valid), .out_ready(out_ready),
    .component_index(component_index), .component_value(component_value),
    .chi_square(chi_square), .tail_error(tail_error), .last_result(last_result)
  );

  always #1 clk = ~clk;

  hit_item_t  pending_hits[$];
  component_t expected_comps[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;
  logic stall_req = 1'b0;
  logic stall_taken = 1'b0;
  int hold_cnt = 0;

  // predictor state
  logic [3:0] tail_cfg = '0;
  longint eig_mat[DIM*DIM];
  longint mean_tab[DIM];
  longint isig_tab[DIM];
  longint ieig_tab[DIM];
  longint coord_buf[DIM];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // floor((v + 2^11) / 2^12)
  function automatic longint round_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic longint sat_acc(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint chi_contrib(input longint p, input longint ie);
    longint a, sq;
    a = (p < 0) ? -p : p;
    if (a >= (64'sd1 << 30)) sq = UMAX;
    else begin
      sq = (a * a + 2048) >>> 12;
      if (sq > UMAX) sq = UMAX;
    end
    return (sq >>> 24) * ie * 4096 + round_q12((sq & 64'hFFFFFF) * ie);
  endfunction

  task automatic project_track();
    longint acc, s, chi;
    bit err;
    component_t c;
    err = (3 * tail_cfg) > DIM;
    chi = 0;
    for (int i = 0; i < DIM; i++) begin
      acc = 0;
      for (int j = 0; j < DIM; j++) begin
        s = round_q12((coord_buf[j] - mean_tab[j]) * isig_tab[j]);
        acc = sat_acc(acc + round_q12(s * eig_mat[j*DIM + i]));
      end
      if (!err && i >= DIM - 3 * tail_cfg) chi += chi_contrib(acc, ieig_tab[i]);
      c.idx = IDX_W'(i);
      c.comp = acc[VAL_W-1:0];
      c.chi = '0;
      c.err = 1'b0;
      c.last = (i == DIM - 1);
      if (c.last) begin
        if (chi < 0) chi = 0;
        if (chi > UMAX) chi = UMAX;
        c.chi = err ? '0 : chi[VAL_W-1:0];
        c.err = err;
      end
      expected_comps.insert(expected_comps.size(), c);
    end
  endtask

  task automatic apply_hit();
    longint v;
    v = longint'(word_value);
    if (req_type == REQ_LOAD) begin
      if (entry_row < DIM) begin
        case (table_select)
          SEL_MATRIX: if (entry_col < DIM) eig_mat[entry_row*DIM + entry_col] = v;
          SEL_MEAN:   mean_tab[entry_row] = v;
          SEL_INVSIG: isig_tab[entry_row] = v;
          SEL_INVEIG: ieig_tab[entry_row] = v;
        endcase
      end
    end else begin
      if (entry_row < DIM) coord_buf[entry_row] = v;
      if (last_coord) project_track();
    end
  endtask

  // acceptance, prediction and checking at the rising edge
  always @(posedge clk) begin
    component_t w;
    in_took <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tail_cfg <= cfg_data;
      if (in_valid && in_ready) apply_hit();
      if (out_valid && out_ready) begin
        if (expected_comps.size() == 0) report_mismatch("unexpected beat", component_index, -1);
        else begin
          w = expected_comps.pop_front();
          if (component_index !== w.idx) report_mismatch("component_index", component_index, w.idx);
          if (component_value !== w.comp)
            report_mismatch("component_value", component_value, $signed(w.comp));
          if (chi_square !== w.chi) report_mismatch("chi_square", chi_square, w.chi);
          if (tail_error !== w.err) report_mismatch("tail_error", tail_error, w.err);
          if (last_result !== w.last) report_mismatch("last_result", last_result, w.last);
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    hit_item_t h;
    if (!rst && (!in_valid || in_took)) begin
      if (pending_hits.size() != 0 && $urandom_range(99) >= snd_idle) begin
        h = pending_hits.pop_front();
        req_type <= h.req;
        table_select <= h.sel;
        entry_row <= h.row;
        entry_col <= h.col;
        word_value <= h.val;
        last_coord <= h.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_cnt <= 700;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic push_hit(input logic req, input logic [1:0] sel, input int row,
                          input int col, input logic [DATA_W-1:0] val, input logic last);
    hit_item_t h;
    h.req = req; h.sel = sel; h.row = 4'(row); h.col = 4'(col); h.val = val; h.last = last;
    pending_hits.insert(pending_hits.size(), h);
  endtask

  // mostly modest values, now and then anything at all
  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(7) == 0) return DATA_W'($urandom);
    return DATA_W'(int'($urandom_range(16383)) - 8192);
  endfunction

  task automatic write_tail(input logic [3:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_hits.size() != 0 || in_valid || expected_comps.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_hits(input int n);
    int sent, k, r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // a whole track, with the odd repeat or out-of-range position
        for (k = 0; k < DIM; k++) begin
          push_hit(REQ_COORD, 2'($urandom),
                   ($urandom_range(9) == 0) ? $urandom_range(15) : k,
                   $urandom_range(15), pick_word(), k == DIM - 1);
          sent++;
        end
      end else if (r < 85) begin
        for (k = 0; k < 3; k++) begin
          push_hit(REQ_LOAD, 2'($urandom), $urandom_range(15), $urandom_range(15),
                   pick_word(), 1'($urandom));
          sent++;
        end
      end else begin
        // short broken track
        for (k = $urandom_range(3); k > 0; k--) begin
          push_hit(REQ_COORD, 2'($urandom), $urandom_range(15), $urandom_range(15),
                   pick_word(), 1'b0);
          sent++;
        end
        push_hit(REQ_COORD, 2'($urandom), $urandom_range(15), $urandom_range(15),
                 pick_word(), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [3:0] tails[5] = '{4'd15, 4'd4, 4'd5, 4'd1, 4'd3};
    foreach (eig_mat[k]) eig_mat[k] = 0;
    for (int k = 0; k < DIM; k++) begin
      mean_tab[k] = 0; isig_tab[k] = 0; ieig_tab[k] = 0; coord_buf[k] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle = 38;
    rcv_idle = 80;
    write_tail(4'd4);

    // every store entry written before the first track is projected
    for (int j = 0; j < DIM; j++)
      for (int i = 0; i < DIM; i++) push_hit(REQ_LOAD, SEL_MATRIX, j, i, pick_word(), 1'b0);
    for (int j = 0; j < DIM; j++) begin
      push_hit(REQ_LOAD, SEL_MEAN, j, 0, pick_word(), 1'b0);
      push_hit(REQ_LOAD, SEL_INVSIG, j, 0, pick_word(), 1'b0);
      push_hit(REQ_LOAD, SEL_INVEIG, j, 0, (j == 11) ? 24'hFFF000 : pick_word(), 1'b0);
    end
    for (int j = 0; j < DIM; j++) push_hit(REQ_COORD, 2'd0, j, 0, pick_word(), j == DIM - 1);

    // directed: extremes, stray indexes, repeats, last mark on a load
    for (int j = 0; j < 4; j++) push_hit(REQ_COORD, 2'd3, j, 15, 24'h7FFFFF, 1'b0);
    push_hit(REQ_LOAD, SEL_MEAN, 0, 0, 24'h800000, 1'b1);
    push_hit(REQ_LOAD, SEL_INVSIG, 0, 15, 24'h7FFFFF, 1'b0);
    push_hit(REQ_LOAD, SEL_MATRIX, 0, 0, 24'h7FFFFF, 1'b0);
    push_hit(REQ_COORD, 2'd0, 0, 0, 24'h7FFFFF, 1'b1);
    push_hit(REQ_LOAD, SEL_MATRIX, 3, 12, 24'h123456, 1'b0);
    push_hit(REQ_LOAD, SEL_INVEIG, 15, 0, 24'h000001, 1'b0);
    push_hit(REQ_LOAD, SEL_MEAN, 0, 0, 24'h000000, 1'b0);
    push_hit(REQ_COORD, 2'd1, 5, 0, 24'h800000, 1'b0);
    push_hit(REQ_COORD, 2'd1, 5, 0, 24'h001000, 1'b0);
    push_hit(REQ_COORD, 2'd2, 14, 9, 24'h555555, 1'b1);
    push_hit(REQ_COORD, 2'd2, 15, 15, 24'hAAAAAA, 1'b1);
    drain();

    write_tail(4'd0);
    push_hit(REQ_COORD, 2'd0, 3, 0, 24'h000800, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_tail(tails[p]);
      case (p)
        0, 1: begin snd_idle = 38; rcv_idle = 80; end
        2, 3: begin snd_idle = 80; rcv_idle = 38; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      if (p == 4) stall_req = 1'b1;
      random_hits(45);
      drain();
    end

    repeat (200) @(negedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
